// File: sv/nsfc_pkg.sv
// Shared types and constants for the NMEA sentence framer and checker.
// No dependencies; imported by nsfc_frame and the top level.
package nsfc_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Framing characters.
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  // One sentence result as produced by the framer.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] checksum;
    logic [7:0] sentence_length;
  } nsfc_result_t;

endpackage

// File: sv/nsfc_frame.sv
// Sentence framing state and checksum check for one byte per beat.
// Depends on nsfc_pkg for framing characters, status codes and the result struct.
module nsfc_frame #(
  parameter int MAX_FRAME = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  output nsfc_pkg::nsfc_result_t result
);
  import nsfc_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  localparam logic [8:0] MaxFrame = 9'(MAX_FRAME);

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] first_digit, first_digit_next;
  logic [8:0] count_inc;
  logic       over;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    hex_upper = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  assign count_inc = {1'b0, byte_count} + 9'd1;
  assign over      = count_inc > MaxFrame;

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    byte_count_next  = byte_count;
    first_digit_next = first_digit;
    result.valid           = 1'b0;
    result.status          = ST_OK;
    result.checksum        = running_xor;
    result.sentence_length = byte_count;
    case (phase)
      PH_WAIT: begin
        if (rx_byte == CH_START) begin
          phase_next       = PH_BODY;
          running_xor_next = 8'd0;
          byte_count_next  = 8'd1;
          first_digit_next = 8'd0;
        end
      end
      default: begin
        if (over) begin
          // The overflowing byte is dropped without being looked at.
          result.valid  = 1'b1;
          result.status = ST_OVERFLOW;
          phase_next    = PH_WAIT;
        end else begin
          byte_count_next = count_inc[7:0];
          case (phase)
            PH_BODY: begin
              if (rx_byte == CH_STAR) begin
                phase_next = PH_DIG1;
              end else begin
                running_xor_next = running_xor ^ rx_byte;
              end
            end
            PH_DIG1: begin
              first_digit_next = rx_byte;
              phase_next       = PH_DIG2;
            end
            PH_DIG2: begin
              result.valid           = 1'b1;
              result.sentence_length = count_inc[7:0];
              result.status = ((first_digit == hex_upper(running_xor[7:4])) &&
                               (rx_byte == hex_upper(running_xor[3:0])))
                              ? ST_OK : ST_MISMATCH;
              phase_next = PH_WAIT;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      running_xor <= 8'd0;
      byte_count  <= 8'd0;
      first_digit <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      byte_count  <= byte_count_next;
      first_digit <= first_digit_next;
    end
  end

  // Inside a sentence the count never passes the frame limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase != PH_WAIT |-> {1'b0, byte_count} <= MaxFrame)
    else $error("byte count exceeds frame limit");

  // A result can only come from a beat inside a sentence.
  a_result_in_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> phase != PH_WAIT)
    else $error("result raised while waiting for start");

  // Every result ends the sentence.
  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    fire && result.valid |=> phase == PH_WAIT)
    else $error("sentence did not end after result");

endmodule

// File: sv/nmea_sentence_framer_checker_top.sv
// Top level of the NMEA sentence framer and checksum checker.
// Depends on nsfc_pkg and nsfc_frame.
//
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// The block waits for '$', XORs the body up to the first '*', then takes
// two checksum characters and compares them with the uppercase hex of the
// XOR. Output channel (out_valid/out_ready): one result per sentence with
// status (ok, mismatch, too long), the computed checksum and the length.
// Sentences longer than MAX_FRAME bytes end early with a too-long status.
// Throughput is one byte per cycle while out_ready keeps up: a byte is
// registered in the input register, runs through the framer logic and
// its result lands in the output register, which drives out_valid.
// When the receiver stalls, the output register holds its result and the
// input register keeps one byte; further bytes wait on in_ready. Reset
// empties both registers and returns the framer to waiting for '$'.
module nmea_sentence_framer_checker_top #(
  parameter int MAX_FRAME = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] checksum,
  output logic [7:0] sentence_length
);
  import nsfc_pkg::*;

  logic         in_q_valid;
  logic [7:0]   in_q_byte;
  logic         out_free;
  logic         fire;
  nsfc_result_t result;

  assign out_free = !out_valid || out_ready;
  assign fire     = in_q_valid && out_free;
  assign in_ready = !in_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_byte <= rx_byte;
    end
  end

  nsfc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (in_q_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && result.valid) begin
      status          <= result.status;
      checksum        <= result.checksum;
      sentence_length <= result.sentence_length;
    end
  end

  // A too-long result always reports exactly the frame limit.
  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> sentence_length == 8'(MAX_FRAME))
    else $error("overflow result with wrong length");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_MISMATCH || status == ST_OVERFLOW)
    else $error("undefined status code");

  // The held byte is only consumed when the output side can take a result.
  a_fire_room: assert property (@(posedge clk) disable iff (rst)
    fire |-> !out_valid || out_ready)
    else $error("framer advanced into a full output register");

endmodule
